### src/bzc_pkg.sv
package bzc_pkg;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // which of the up to three control points is being produced
  typedef enum logic [1:0] {
    PH_THIRD_A  = 2'd0,
    PH_THIRD_B  = 2'd1,
    PH_JUNCTION = 2'd2
  } phase_t;

  // one point's worth of work handed from the history to the result side
  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
    phase_t first_phase;
  } job_t;

  // 3 * 2^33 lifts any 34-bit signed value into the non-negative range
  localparam logic [34:0] DIV3_OFFSET = 35'h6_0000_0000;
  // (2^18 - 1) / 3
  localparam logic [16:0] DIV3_HIGH_WEIGHT = 17'd87381;
  // ceil(2^20 / 3), exact for operands below 2^19
  localparam logic [18:0] DIV3_RECIP = 19'd349526;

  // floor(s / 3) for a 34-bit signed operand, low 32 bits of the quotient
  function automatic logic [31:0] div3_floor(input logic signed [33:0] s);
    logic [34:0] y;
    logic [16:0] yh;
    logic [17:0] yl;
    logic [18:0] t;
    logic [37:0] tq;
    logic [33:0] hq;
    y  = 35'(s) + DIV3_OFFSET;
    yh = y[34:18];
    yl = y[17:0];
    // 2^18 = 1 mod 3, so y = yh * (2^18 - 1) + (yh + yl)
    t  = 19'(yh) + 19'(yl);
    tq = 38'(t) * 38'(DIV3_RECIP);
    hq = 34'(yh) * 34'(DIV3_HIGH_WEIGHT);
    // the offset removed again is a multiple of 2^32 once divided by 3
    return hq[31:0] + 32'(tq[37:20]);
  endfunction

endpackage

### src/bzc_history.sv
module bzc_history import bzc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  point_t point,
  input  logic   curve_start,
  output logic   has_results,
  output job_t   job
);

  point_t     a;
  point_t     b;
  logic [1:0] points_seen;
  logic [1:0] seen_eff;
  logic [1:0] points_seen_next;

  assign seen_eff = curve_start ? 2'd0 : points_seen;
  assign has_results = (seen_eff >= 2'd2);
  assign points_seen_next = (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;

  always_comb begin
    job.a = a;
    job.b = b;
    job.c = point;
    job.first_phase = (seen_eff == 2'd3) ? PH_THIRD_A : PH_JUNCTION;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a           <= '0;
      b           <= '0;
      points_seen <= 2'd0;
    end else if (accept) begin
      a           <= b;
      b           <= point;
      points_seen <= points_seen_next;
    end
  end

endmodule

### src/bzc_coord.sv
module bzc_coord import bzc_pkg::*; (
  input  coord_t a,
  input  coord_t b,
  input  coord_t c,
  input  phase_t phase,
  output coord_t res
);

  logic signed [33:0] two_a_b;
  logic signed [33:0] a_two_b;
  logic signed [34:0] junction_sum;
  logic signed [33:0] junction_half;
  logic signed [33:0] dividend;

  assign two_a_b = (34'(a) <<< 1) + 34'(b);
  assign a_two_b = 34'(a) + (34'(b) <<< 1);
  assign junction_sum = 35'(a) + (35'(b) <<< 2) + 35'(c);
  // floor halving, then floor third, gives floor of a sixth
  assign junction_half = junction_sum[34:1];

  always_comb begin
    unique case (phase)
      PH_THIRD_A:  dividend = two_a_b;
      PH_THIRD_B:  dividend = a_two_b;
      PH_JUNCTION: dividend = junction_half;
      default:     dividend = junction_half;
    endcase
  end

  assign res = coord_t'(div3_floor(dividend));

endmodule

### src/bspline_to_bezier_converter.sv
// uniform cubic b-spline to bezier converter: takes de boor points (signed q16.16 x, y, z)
// and emits bezier control points. the first two points of a curve give nothing, the third
// gives the junction (a + 4b + c) / 6, and every later point gives (2a + b) / 3, (a + 2b) / 3
// and then the junction, all floored; last_in_run marks the final result of each point.
// curve_start clears the point count before the point is taken. a point that produces results
// occupies the block until its last result is loaded into the result register, and a point
// producing nothing is absorbed without touching the result side; the single result register
// delivers one control point per cycle while no waiting result is held by out_stall. the next
// point is taken in the same cycle as the last result of the previous one is registered, and
// a result waiting in the output register holds the result logic only while out_stall is high.
module bspline_to_bezier_converter import bzc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic          curve_start,
  output logic          out_valid,
  input  logic          out_stall,
  output logic signed [31:0] bez_x,
  output logic signed [31:0] bez_y,
  output logic signed [31:0] bez_z,
  output logic          last_in_run
);

  // input side
  logic   in_accept;
  point_t in_point;
  logic   has_results;
  job_t   new_job;

  // job register: the three points behind the results being produced
  logic   job_valid;
  logic   job_valid_next;
  job_t   job;
  phase_t phase;
  phase_t phase_next;

  // result side
  logic   out_load;
  logic   job_done;
  coord_t res_x;
  coord_t res_y;
  coord_t res_z;
  logic   out_valid_next;

  assign in_point = '{x: point_x, y: point_y, z: point_z};

  // the result register can take a new control point when empty or being drained
  assign out_load  = job_valid && (!out_valid || !out_stall);
  assign job_done  = out_load && (phase == PH_JUNCTION);
  assign in_stall  = job_valid && !job_done;
  assign in_accept = in_valid && !in_stall;

  bzc_history u_history (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .point       (in_point),
    .curve_start (curve_start),
    .has_results (has_results),
    .job         (new_job)
  );

  // job control: a transaction with results loads a job, the junction result retires it
  always_comb begin
    priority if (in_accept && has_results) begin
      job_valid_next = 1'b1;
    end else if (job_done) begin
      job_valid_next = 1'b0;
    end else begin
      job_valid_next = job_valid;
    end
  end

  always_comb begin
    priority if (in_accept) begin
      phase_next = new_job.first_phase;
    end else if (out_load) begin
      unique case (phase)
        PH_THIRD_A:  phase_next = PH_THIRD_B;
        PH_THIRD_B:  phase_next = PH_JUNCTION;
        PH_JUNCTION: phase_next = PH_JUNCTION;
        default:     phase_next = PH_JUNCTION;
      endcase
    end else begin
      phase_next = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase     <= PH_JUNCTION;
    end else begin
      job_valid <= job_valid_next;
      phase     <= phase_next;
    end
  end

  // job payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept && has_results) begin
      job <= new_job;
    end
  end

  // one weighting and floor-divide unit per coordinate
  bzc_coord u_coord_x (
    .a     (job.a.x),
    .b     (job.b.x),
    .c     (job.c.x),
    .phase (phase),
    .res   (res_x)
  );

  bzc_coord u_coord_y (
    .a     (job.a.y),
    .b     (job.b.y),
    .c     (job.c.y),
    .phase (phase),
    .res   (res_y)
  );

  bzc_coord u_coord_z (
    .a     (job.a.z),
    .b     (job.b.z),
    .c     (job.c.z),
    .phase (phase),
    .res   (res_z)
  );

  // output register
  always_comb begin
    priority if (out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bez_x       <= res_x;
      bez_y       <= res_y;
      bez_z       <= res_z;
      last_in_run <= (phase == PH_JUNCTION);
    end
  end

endmodule
